FILE: rtl/ddo_pkg.sv
package ddo_pkg;

  localparam int PosW = 32;
  localparam int AngW = 16;

  // Heading format constants (Q2.13)
  localparam logic signed [48:0] PI_Q        = 49'sd25736;
  localparam logic signed [48:0] PI_Q_M1     = 49'sd25735;
  localparam logic [41:0]        TWO_PI_Q    = 42'd51472;

  // CORDIC angle constants (Q29) and start value (Q30)
  localparam logic signed [32:0] PI_Z        = 33'sd1686629713;
  localparam logic signed [32:0] HALF_PI_Z   = 33'sd843314856;
  localparam logic signed [33:0] INV_GAIN    = 34'sd652032874;

  localparam logic signed [31:0] POS_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] POS_MIN     = 32'sh8000_0000;

  // Iteration counts, stored as last count value
  localparam logic [5:0] DIV_LAST  = 6'd63;
  localparam logic [5:0] MUL_LAST  = 6'd31;
  localparam logic [5:0] CORD_LAST = 6'd15;

  // Configuration register indexes
  localparam logic [1:0] CFG_LEFT_DPT  = 2'd0;
  localparam logic [1:0] CFG_RIGHT_DPT = 2'd1;
  localparam logic [1:0] CFG_AXLE      = 2'd2;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_DIST   = 12'b0000_0000_0010,
    S_DECIDE = 12'b0000_0000_0100,
    S_DTH    = 12'b0000_0000_1000,
    S_WRAP   = 12'b0000_0001_0000,
    S_TURN   = 12'b0000_0010_0000,
    S_RMUL   = 12'b0000_0100_0000,
    S_RDIV   = 12'b0000_1000_0000,
    S_CORD1  = 12'b0001_0000_0000,
    S_CORD2  = 12'b0010_0000_0000,
    S_TMUL   = 12'b0100_0000_0000,
    S_FIN    = 12'b1000_0000_0000
  } state_t;

  // arctan(2^-i) in Q29
  function automatic logic [31:0] atan_q29(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd421657428;
      5'd1:  v = 32'd248918915;
      5'd2:  v = 32'd131521918;
      5'd3:  v = 32'd66762579;
      5'd4:  v = 32'd33510843;
      5'd5:  v = 32'd16771758;
      5'd6:  v = 32'd8387925;
      5'd7:  v = 32'd4194219;
      5'd8:  v = 32'd2097141;
      5'd9:  v = 32'd1048575;
      5'd10: v = 32'd524288;
      5'd11: v = 32'd262144;
      5'd12: v = 32'd131072;
      5'd13: v = 32'd65536;
      5'd14: v = 32'd32768;
      5'd15: v = 32'd16384;
      5'd16: v = 32'd8192;
      5'd17: v = 32'd4096;
      5'd18: v = 32'd2048;
      5'd19: v = 32'd1024;
      5'd20: v = 32'd512;
      5'd21: v = 32'd256;
      5'd22: v = 32'd128;
      5'd23: v = 32'd64;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/differential_drive_odometry_core.sv
// Straight update: CORDIC on the old heading, then the multipliers. Arc update: heading
//   divide (and a turn divide for the multi-turn reduction), radius multiply and divide,
//   CORDIC on old and new heading, then multiply. Inputs are taken only in idle, one item
//   at a time; bit-serial divider (64 steps per quotient), multipliers (32), CORDIC (16).
// Reset (rst, synchronous): pose cleared to zero, config registers to defaults, output empty.
module differential_drive_odometry_core
  import ddo_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] left_ticks, [31:16] right_ticks
  input  logic        s_tuser,   // [0] straight
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [31:0] out_x, [63:32] out_y, [79:64] out_heading
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  // Configuration
  logic [23:0] left_dpt, right_dpt, axle;
  logic [23:0] axle_e;

  // Pose
  logic signed [31:0] x_pos, y_pos;
  logic signed [15:0] heading;

  state_t state;
  logic [5:0] cnt;

  // Item operands
  logic signed [15:0] tick_l, tick_r;
  logic               straight_r;
  logic               is_arc;
  logic signed [40:0] dist_l, dist_r;
  logic signed [41:0] dist_s;
  logic [40:0]        md_r, smag_r;
  logic               diff_neg, rneg, turn_neg;
  logic signed [15:0] nh_r;

  // Bit-serial restoring divider: quotient shifts into div_d
  logic [63:0] div_d, dd_nx;
  logic [41:0] div_r, div_v, dr_nx;
  logic [42:0] dtrial;
  logic        dge;

  // Bit-serial multipliers, one multiplier bit per cycle, shared multiplicand
  logic [63:0] mul_a;
  logic [96:0] px, py, px_nx, py_nx;
  logic [64:0] px_sum, py_sum;
  logic        sh39, negx, negy;

  // CORDIC
  logic signed [33:0] cx, cy, cx_nx, cy_nx, sxs, sys;
  logic signed [32:0] cz, cz_nx, cat;
  logic               cflip;
  logic signed [15:0] ang_sel;
  logic signed [32:0] cz0, cz_init;
  logic               flip_init;
  logic signed [33:0] run_c, run_s, co, so;

  // Misc combinational
  logic signed [16:0] tick_sum, tick_avg;
  logic [24:0]        lr_dpt;
  logic signed [41:0] diff, sum;
  logic [40:0]        md, smag, dist_mag;
  logic signed [48:0] nh_w, turn_t;
  logic signed [34:0] ts, tc;
  logic [31:0]        c_mag, s_mag, ts_mag, tc_mag;
  logic signed [31:0] x_new, y_new;

  assign axle_e   = (axle == 24'd0) ? 24'd1 : axle;
  assign s_tready = (state == S_IDLE);

  // Round to Q16 half away from zero, apply sign, add to position and saturate.
  function automatic logic signed [31:0] round_sat(input logic [96:0] p,
                                                   input logic sh,
                                                   input logic neg,
                                                   input logic signed [31:0] pos);
    logic [66:0]        q;
    logic               rb;
    logic [67:0]        mag;
    logic               big;
    logic signed [35:0] dm, acc;
    logic signed [31:0] r;
    q   = sh ? 67'(p[96:39]) : p[96:30];
    rb  = sh ? p[38] : p[29];
    mag = 68'(q) + 68'(rb);
    big = |mag[67:33];
    dm  = $signed(36'(mag[32:0]));
    acc = 36'(pos) + (neg ? -dm : dm);
    if (big) begin
      r = neg ? POS_MIN : POS_MAX;
    end else if (acc > 36'(POS_MAX)) begin
      r = POS_MAX;
    end else if (acc < 36'(POS_MIN)) begin
      r = POS_MIN;
    end else begin
      r = acc[31:0];
    end
    return r;
  endfunction

  always_comb begin
    // tick average truncated toward zero
    tick_sum = 17'(tick_l) + 17'(tick_r);
    tick_avg = (tick_sum + (tick_sum[16] ? 17'sd1 : 17'sd0)) >>> 1;
    lr_dpt   = 25'(left_dpt) + 25'(right_dpt);

    diff     = 42'(dist_r) - 42'(dist_l);
    sum      = 42'(dist_r) + 42'(dist_l);
    md       = diff[41] ? 41'(-diff) : 41'(diff);
    smag     = sum[41] ? 41'(-sum) : 41'(sum);
    dist_mag = dist_s[41] ? 41'(-dist_s) : 41'(dist_s);

    // divider step
    dtrial = {div_r, div_d[63]};
    dge    = dtrial >= {1'b0, div_v};
    dr_nx  = dge ? 42'(dtrial - {1'b0, div_v}) : dtrial[41:0];
    dd_nx  = {div_d[62:0], dge};

    // heading after the wheel-difference turn, and the turn-count dividend
    nh_w = 49'(heading) + (diff_neg ? -$signed(49'(div_d[46:0]))
                                    : $signed(49'(div_d[46:0])));
    turn_t = (nh_w > PI_Q) ? (nh_w + PI_Q_M1) : (PI_Q_M1 - nh_w);

    // multiplier step
    px_sum = px[96:32] + (px[0] ? {1'b0, mul_a} : 65'd0);
    py_sum = py[96:32] + (py[0] ? {1'b0, mul_a} : 65'd0);
    px_nx  = {1'b0, px_sum, px[31:1]};
    py_nx  = {1'b0, py_sum, py[31:1]};

    // CORDIC start: fold angles beyond pi/2 by a half turn
    ang_sel = (state == S_CORD1) ? nh_r : heading;
    cz0     = {ang_sel[15], ang_sel, 16'h0000};
    if (cz0 > HALF_PI_Z) begin
      cz_init   = cz0 - PI_Z;
      flip_init = 1'b1;
    end else if (cz0 < -HALF_PI_Z) begin
      cz_init   = cz0 + PI_Z;
      flip_init = 1'b1;
    end else begin
      cz_init   = cz0;
      flip_init = 1'b0;
    end

    // CORDIC micro-rotation
    sxs = cx >>> cnt[3:0];
    sys = cy >>> cnt[3:0];
    cat = $signed({1'b0, atan_q29(cnt[4:0])});
    if (!cz[32]) begin
      cx_nx = cx - sys;
      cy_nx = cy + sxs;
      cz_nx = cz - cat;
    end else begin
      cx_nx = cx + sys;
      cy_nx = cy - sxs;
      cz_nx = cz + cat;
    end
    run_c = cflip ? -cx_nx : cx_nx;
    run_s = cflip ? -cy_nx : cy_nx;

    c_mag  = run_c[33] ? 32'(-run_c) : 32'(run_c);
    s_mag  = run_s[33] ? 32'(-run_s) : 32'(run_s);
    ts     = 35'(run_s) - 35'(so);
    tc     = 35'(co) - 35'(run_c);
    ts_mag = ts[34] ? 32'(-ts) : 32'(ts);
    tc_mag = tc[34] ? 32'(-tc) : 32'(tc);

    x_new = round_sat(px, sh39, negx, x_pos);
    y_new = round_sat(py, sh39, negy, y_pos);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      m_tvalid  <= 1'b0;
      left_dpt  <= 24'd16777;
      right_dpt <= 24'd16777;
      axle      <= 24'd13107;
      x_pos     <= '0;
      y_pos     <= '0;
      heading   <= '0;
      cnt       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LEFT_DPT:  left_dpt  <= cfg_data;
          CFG_RIGHT_DPT: right_dpt <= cfg_data;
          CFG_AXLE:      axle      <= cfg_data;
          default: ;
        endcase
      end

      // the finish step reloads the output itself
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            tick_l     <= s_tdata[15:0];
            tick_r     <= s_tdata[31:16];
            straight_r <= s_tuser;
            state      <= S_DIST;
          end
        end

        S_DIST: begin
          dist_l <= $signed({1'b0, left_dpt}) * tick_l;
          dist_r <= $signed({1'b0, right_dpt}) * tick_r;
          dist_s <= 42'($signed({1'b0, lr_dpt}) * tick_avg);
          state  <= S_DECIDE;
        end

        S_DECIDE: begin
          md_r     <= md;
          smag_r   <= smag;
          diff_neg <= diff[41];
          rneg     <= sum[41] ^ diff[41];
          cnt      <= '0;
          if (straight_r || diff == 42'sd0) begin
            // straight update, also taken for a zero wheel difference
            is_arc <= 1'b0;
            cx     <= INV_GAIN;
            cy     <= '0;
            cz     <= cz_init;
            cflip  <= flip_init;
            state  <= S_CORD1;
          end else begin
            // heading change = round(diff * 2^13 / (axle * 2^8))
            is_arc <= 1'b1;
            div_d  <= 64'({md, 13'h0000}) + 64'({axle_e, 7'h00});
            div_v  <= 42'({axle_e, 8'h00});
            div_r  <= '0;
            state  <= S_DTH;
          end
        end

        S_DTH: begin
          div_d <= dd_nx;
          div_r <= dr_nx;
          cnt   <= cnt + 6'd1;
          if (cnt == DIV_LAST) begin
            state <= S_WRAP;
          end
        end

        S_WRAP: begin
          cnt <= '0;
          if (nh_w > PI_Q || nh_w < -PI_Q) begin
            // whole turns to remove = ceil(excess / 2pi); only the remainder is kept
            turn_neg <= (nh_w < -PI_Q);
            div_d    <= 64'(turn_t);
            div_v    <= TWO_PI_Q;
            div_r    <= '0;
            state    <= S_TURN;
          end else begin
            nh_r  <= nh_w[15:0];
            mul_a <= 64'(smag_r);
            px    <= {65'd0, 32'(axle_e)};
            state <= S_RMUL;
          end
        end

        S_TURN: begin
          div_d <= dd_nx;
          div_r <= dr_nx;
          if (cnt == DIV_LAST) begin
            nh_r  <= turn_neg ? 16'(18'd25735 - 18'(dr_nx[16:0]))
                              : 16'(18'(dr_nx[16:0]) - 18'd25735);
            mul_a <= 64'(smag_r);
            px    <= {65'd0, 32'(axle_e)};
            cnt   <= '0;
            state <= S_RMUL;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end

        S_RMUL: begin
          // |sum| * axle
          px <= px_nx;
          if (cnt == MUL_LAST) begin
            // radius = (|sum| * axle + |diff|) / (2 |diff|)
            div_d <= px_nx[63:0] + 64'(md_r);
            div_v <= {md_r, 1'b0};
            div_r <= '0;
            cnt   <= '0;
            state <= S_RDIV;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end

        S_RDIV: begin
          div_d <= dd_nx;
          div_r <= dr_nx;
          if (cnt == DIV_LAST) begin
            mul_a <= dd_nx;
            cx    <= INV_GAIN;
            cy    <= '0;
            cz    <= cz_init;
            cflip <= flip_init;
            cnt   <= '0;
            state <= S_CORD1;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end

        S_CORD1: begin
          // trig of the old heading
          if (cnt == CORD_LAST) begin
            co  <= run_c;
            so  <= run_s;
            cnt <= '0;
            if (is_arc) begin
              cx    <= INV_GAIN;
              cy    <= '0;
              cz    <= cz_init;
              cflip <= flip_init;
              state <= S_CORD2;
            end else begin
              mul_a <= 64'(dist_mag);
              px    <= {65'd0, c_mag};
              py    <= {65'd0, s_mag};
              negx  <= dist_s[41] ^ run_c[33];
              negy  <= dist_s[41] ^ run_s[33];
              sh39  <= 1'b1;
              state <= S_TMUL;
            end
          end else begin
            cx  <= cx_nx;
            cy  <= cy_nx;
            cz  <= cz_nx;
            cnt <= cnt + 6'd1;
          end
        end

        S_CORD2: begin
          // trig of the new heading
          cx <= cx_nx;
          cy <= cy_nx;
          cz <= cz_nx;
          if (cnt == CORD_LAST) begin
            px    <= {65'd0, ts_mag};
            py    <= {65'd0, tc_mag};
            negx  <= rneg ^ ts[34];
            negy  <= rneg ^ tc[34];
            sh39  <= 1'b0;
            cnt   <= '0;
            state <= S_TMUL;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end

        S_TMUL: begin
          px  <= px_nx;
          py  <= py_nx;
          cnt <= cnt + 6'd1;
          if (cnt == MUL_LAST) begin
            state <= S_FIN;
          end
        end

        S_FIN: begin
          // wait for the output register to free up
          if (!m_tvalid || m_tready) begin
            x_pos    <= x_new;
            y_pos    <= y_new;
            if (is_arc) begin
              heading <= nh_r;
            end
            m_tdata  <= {(is_arc ? nh_r : heading), y_new, x_new};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_DIST)
    else $error("accepted transaction did not start processing");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_FIN))
    else $error("output valid raised outside finish step");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    heading <= 16'sd25736 && heading >= -16'sd25736)
    else $error("heading outside minus pi to pi");

  a_fin_stall: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && m_tvalid && !m_tready |=> state == S_FIN)
    else $error("result lost while output stalled");

endmodule
